// ===== design/mtpa_pkg.sv =====
// ----------------------------------------------------------------------------
// MTPA d-axis current reference: shared types and codes
// Result status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package mtpa_pkg;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_DIV_ERR = 2'd2
  } status_e;

  localparam logic [1:0] REG_FLUX = 2'd0;
  localparam logic [1:0] REG_LD   = 2'd1;
  localparam logic [1:0] REG_LQ   = 2'd2;

endpackage

// ===== design/mtpa_sqrt.sv =====
// ----------------------------------------------------------------------------
// MTPA pipelined square root
// Restoring digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module mtpa_sqrt import mtpa_pkg::*; #(
  parameter int RW = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*RW-1:0] rad_i,
  output logic            valid_o,
  output logic [RW-1:0]   root_o
);

  logic [RW-1:0]   v_q;
  logic [2*RW-1:0] rad_q  [RW];
  logic [RW+1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic            v_in;
    logic [2*RW-1:0] rad_in;
    logic [RW+1:0]   rem_in;
    logic [RW-1:0]   root_in;
    logic [RW+1:0]   rem_sh;
    logic [RW+1:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign rem_sh = {rem_in[RW-1:0], rad_in[2*RW-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {rad_in[2*RW-3:0], 2'b00};
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[RW-2:0], ge};
      end
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = root_q[RW-1];

endmodule

// ===== design/mtpa_div.sv =====
// ----------------------------------------------------------------------------
// MTPA pipelined divider
// Restoring unsigned division, one quotient bit per stage; the user must hold the divisor static (not checked).
// ----------------------------------------------------------------------------
module mtpa_div import mtpa_pkg::*; #(
  parameter int NW = 47,
  parameter int DW = 31
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic          flag_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          valid_o,
  output logic          flag_o,
  output logic [NW-1:0] quo_o
);

  logic [NW-1:0] v_q;
  logic [NW-1:0] f_q;
  logic [NW-1:0] num_q [NW];
  logic [DW:0]   rem_q [NW];
  logic [NW-1:0] quo_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          v_in;
    logic          f_in;
    logic [NW-1:0] num_in;
    logic [DW:0]   rem_in;
    logic [NW-1:0] quo_in;
    logic [DW:0]   rem_sh;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign f_in   = flag_i;
      assign num_in = num_i;
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign f_in   = f_q[k-1];
      assign num_in = num_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign rem_sh = {rem_in[DW-1:0], num_in[NW-1]};
    assign ge     = (rem_sh >= {1'b0, den_i});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        f_q[k]   <= f_in;
        num_q[k] <= {num_in[NW-2:0], 1'b0};
        rem_q[k] <= ge ? (rem_sh - {1'b0, den_i}) : rem_sh;
        quo_q[k] <= {quo_in[NW-2:0], ge};
      end
    end
  end

  assign valid_o = v_q[NW-1];
  assign flag_o  = f_q[NW-1];
  assign quo_o   = quo_q[NW-1];

endmodule

// ===== design/mtpa_d_current_reference.sv =====
// ----------------------------------------------------------------------------
// MTPA d-axis current reference
// id = (flux - sqrt(flux^2 + 4*(Lq-Ld)^2*iq^2)) / (2*(Lq-Ld)), clamped <= 0.
//
// channel   dir  tdata fields (low bit up)             tuser/tlast
// s_axis    in   q_current                             -
// m_axis    out  d_current_ref, status                 -
// cfg       in   write enable, register index, data    -
//
// One transaction per cycle unless the output stalls; data passes stages 1-4,
// the square root with RW = (DATA_WIDTH+FRAC_BITS)/2 + 1 (one bit per stage),
// stage 6, the divider with NW = DATA_WIDTH-1+FRAC_BITS (one bit per stage) and the output register.
// The whole pipeline advances when the output register is empty or taken.
// Reset clears all valid bits and the configuration registers to zero; data registers are not reset.
// ----------------------------------------------------------------------------
module mtpa_d_current_reference import mtpa_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [1:0]                             cfg_addr_i,
  input  logic [DATA_WIDTH-1:0]                  cfg_data_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // q_current
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // d_current_ref, status
  output logic [((DATA_WIDTH+2+7)/8)*8-1:0]      m_axis_tdata
);

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int UW   = W - 1;
  localparam int RW   = (W + F) / 2 + 1;
  localparam int NW   = W - 1 + F;
  localparam int XW   = RW + W;
  localparam int OW   = ((W + 2 + 7) / 8) * 8;
  localparam logic [UW-1:0] MAXV = {UW{1'b1}};

  // configuration
  logic [W-1:0] flux_q, ld_q, lq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flux_q <= '0;
      ld_q   <= '0;
      lq_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_FLUX: flux_q <= cfg_data_i;
        REG_LD:   ld_q   <= cfg_data_i;
        REG_LQ:   lq_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic          cfg_bad, no_saliency;
  logic [W-1:0]  delta_w;
  logic [UW-1:0] flux_u, delta_u, den_u;
  logic [W-1:0]  den_sum;

  assign cfg_bad     = flux_q[W-1] | ld_q[W-1] | lq_q[W-1];
  assign no_saliency = ($signed(lq_q) <= $signed(ld_q));
  assign delta_w     = lq_q - ld_q;
  assign flux_u      = flux_q[UW-1:0];
  assign delta_u     = delta_w[UW-1:0];
  assign den_sum     = {1'b0, delta_u} + {1'b0, delta_u};
  assign den_u       = (den_sum > {1'b0, MAXV}) ? MAXV : den_sum[UW-1:0];

  function automatic logic [UW-1:0] sat_mul(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [2*W-1:0] p;
    logic [2*W-1:0] s;
    begin
      p = a * b;
      s = p >> F;
      sat_mul = (s > {{(W+1){1'b0}}, MAXV}) ? MAXV : s[UW-1:0];
    end
  endfunction

  logic en;
  logic out_v_q;
  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: magnitude of q current
  logic         v1_q;
  logic [W-1:0] mag_q;
  logic [W-1:0] iq_in;
  assign iq_in = s_axis_tdata[W-1:0];

  // stage 2: squares
  logic          v2_q;
  logic [UW-1:0] fsq_q, dd_q, ii_q;

  // stage 3: delta^2 * iq^2
  logic          v3_q;
  logic [UW-1:0] fsq3_q, term_q;

  // stage 4: radicand
  logic          v4_q;
  logic [UW-1:0] sum_q;
  logic [W:0]    term4;
  logic [UW-1:0] term4_sat;
  logic [W-1:0]  sum_w;

  assign term4     = {term_q, 2'b00};
  assign term4_sat = (term4 > {2'b00, MAXV}) ? MAXV : term4[UW-1:0];
  assign sum_w     = {1'b0, fsq3_q} + {1'b0, term4_sat};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q  <= iq_in[W-1] ? (~iq_in + 1'b1) : iq_in;
      fsq_q  <= sat_mul({1'b0, flux_u}, {1'b0, flux_u});
      dd_q   <= sat_mul({1'b0, delta_u}, {1'b0, delta_u});
      ii_q   <= sat_mul(mag_q, mag_q);
      fsq3_q <= fsq_q;
      term_q <= sat_mul({1'b0, dd_q}, {1'b0, ii_q});
      sum_q  <= (sum_w > {1'b0, MAXV}) ? MAXV : sum_w[UW-1:0];
    end
  end

  // square root of sum * 2^F
  logic [2*RW-1:0] rad;
  logic            v5;
  logic [RW-1:0]   root;
  assign rad = (2*RW)'({sum_q, {F{1'b0}}});

  mtpa_sqrt #(.RW(RW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .rad_i   (rad),
    .valid_o (v5),
    .root_o  (root)
  );

  // stage 6: saturated root against flux
  logic          v6_q, pos_q;
  logic [UW-1:0] diff_q;
  logic [XW-1:0] root_x;
  logic [UW-1:0] root_s;
  assign root_x = XW'(root);
  assign root_s = (root_x > XW'(MAXV)) ? MAXV : root_x[UW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_q  <= (root_s >= flux_u);
      diff_q <= (root_s >= flux_u) ? (root_s - flux_u) : (flux_u - root_s);
    end
  end

  logic          v7, pos7;
  logic [NW-1:0] quo;

  mtpa_div #(.NW(NW), .DW(UW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .flag_i  (pos_q),
    .num_i   ({diff_q, {F{1'b0}}}),
    .den_i   (den_u),
    .valid_o (v7),
    .flag_o  (pos7),
    .quo_o   (quo)
  );

  // output register
  logic [W-1:0] dref_q, dref_d;
  status_e      status_q, status_d;
  logic         ovf;
  logic [NW:0]  quo_x;
  assign quo_x = {1'b0, quo};
  assign ovf   = pos7 ? (quo_x > (NW+1)'({1'b1, {UW{1'b0}}}))
                      : (quo_x > (NW+1)'(MAXV));

  always_comb begin
    dref_d   = '0;
    status_d = STATUS_OK;
    if (cfg_bad) begin
      status_d = STATUS_INVALID;
    end else if (no_saliency) begin
      status_d = STATUS_OK;
    end else if (ovf) begin
      status_d = STATUS_DIV_ERR;
    end else if (pos7) begin
      dref_d = ~quo[W-1:0] + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= v7;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dref_q   <= dref_d;
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OW'({status_q, dref_q});

`ifndef ASSERT_OFF
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (status_q == STATUS_OK || status_q == STATUS_INVALID ||
                       status_q == STATUS_DIV_ERR))
    else $error("illegal status code");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status_q != STATUS_OK) |-> (dref_q == '0))
    else $error("nonzero reference with error status");

  a_never_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (dref_q[W-1] || dref_q == '0))
    else $error("positive d-axis reference");
`endif

endmodule
